// ===== sv/imm_pkg.sv =====
// Shared constants for the interleaved modular multiplier.
// No dependencies; imported by imm_slice, the top level and the testbench.
package imm_pkg;

  localparam int WORD_W = 16;
  localparam int DEF_OPERAND_WORDS = 16;
  localparam int SIG_W = 5;

endpackage

// ===== sv/imm_slice.sv =====
// One 16-bit digit of the datapath: doubling with compare-subtract and
// conditional add with compare-subtract. Depends on imm_pkg.
module imm_slice (
  input  logic [imm_pkg::WORD_W-1:0] dcur,
  input  logic [imm_pkg::WORD_W-1:0] m,
  input  logic                       din,
  input  logic                       dbin,
  input  logic [imm_pkg::WORD_W-1:0] acur,
  input  logic                       abit,
  input  logic                       acin,
  input  logic                       abin,
  output logic [imm_pkg::WORD_W-1:0] ds,
  output logic [imm_pkg::WORD_W-1:0] dt,
  output logic                       dbout,
  output logic [imm_pkg::WORD_W-1:0] as,
  output logic [imm_pkg::WORD_W-1:0] at,
  output logic                       acout,
  output logic                       about
);
  import imm_pkg::*;

  logic [WORD_W-1:0] addend;
  logic [WORD_W:0]   dsub;
  logic [WORD_W:0]   asum;
  logic [WORD_W:0]   asub;

  always_comb begin
    ds     = {dcur[WORD_W-2:0], din};
    dsub   = {1'b0, ds} - {1'b0, m} - {{WORD_W{1'b0}}, dbin};
    dt     = dsub[WORD_W-1:0];
    dbout  = dsub[WORD_W];
    addend = abit ? dcur : '0;
    asum   = {1'b0, acur} + {1'b0, addend} + {{WORD_W{1'b0}}, acin};
    as     = asum[WORD_W-1:0];
    acout  = asum[WORD_W];
    asub   = {1'b0, as} - {1'b0, m} - {{WORD_W{1'b0}}, abin};
    at     = asub[WORD_W-1:0];
    about  = asub[WORD_W];
  end

endmodule

// ===== sv/interleaved_modular_multiply_top.sv =====
// Interleaved modular multiplier, top level. Depends on imm_pkg and imm_slice.
// After the final input transaction the block reduces the multiplicand, applies
// the multiplier and scans the product, then emits one result per cycle unless
// out_ready stalls; it takes no new input before its last result. Each ring
// pass moves one 16-bit word per cycle, and each operand bit takes one pass.
// Reset (rst, synchronous) returns to loading with no results pending.
module interleaved_modular_multiply_top #(
  parameter int OPERAND_WORDS = imm_pkg::DEF_OPERAND_WORDS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imm_pkg::WORD_W-1:0]  multiplier_word,
  input  logic [imm_pkg::WORD_W-1:0]  multiplicand_word,
  input  logic [imm_pkg::WORD_W-1:0]  modulus_word,
  input  logic                        final_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [imm_pkg::WORD_W-1:0]  product_word,
  output logic [imm_pkg::SIG_W-1:0]   significant_words,
  output logic                        modulus_zero,
  output logic                        final_result
);
  import imm_pkg::*;

  // Values are kept in rings of N+1 words (N = OPERAND_WORDS); the extra word is
  // headroom for the sum of two reduced values before the compare-subtract.
  localparam int W     = OPERAND_WORDS + 1;
  localparam int CNT_W = $clog2(W);
  localparam int BITS  = WORD_W * OPERAND_WORDS;
  localparam int BIT_W = $clog2(BITS);

  typedef enum logic [2:0] {LOAD, REDUCE, MULT, SCAN, EMIT} state_t;

  state_t state;

  // Modulus ring and the two candidate rings of each running value. Every
  // pass writes both the plain result (S) and the result minus the modulus
  // (T); the final borrow of T picks which one is the reduced value.
  logic [WORD_W-1:0] mring [W];
  logic [WORD_W-1:0] d_s   [W];
  logic [WORD_W-1:0] d_t   [W];
  logic [WORD_W-1:0] a_s   [W];
  logic [WORD_W-1:0] a_t   [W];
  logic              dsel;
  logic              asel;

  // Multiplier is consumed low bit first, multiplicand high bit first.
  logic [BITS-1:0]   mult;
  logic [BITS-1:0]   mc;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  wcnt;
  logic [BIT_W-1:0]  bcnt;
  logic [CNT_W-1:0]  sig;
  logic              mnz;

  // Digit-to-digit carries of the current pass.
  logic              dtop;
  logic              dbor;
  logic              acar;
  logic              abor;

  logic              first;
  logic              last_word;
  logic              last_bit;
  logic [WORD_W-1:0] dcur;
  logic [WORD_W-1:0] acur;
  logic              din;
  logic              dbin;
  logic              acin;
  logic              abin;
  logic              abit;
  logic [WORD_W-1:0] ds;
  logic [WORD_W-1:0] dt;
  logic [WORD_W-1:0] as;
  logic [WORD_W-1:0] at;
  logic              dbout;
  logic              acout;
  logic              about;
  logic              in_take;
  logic              store;
  logic              mnz_next;
  logic [CNT_W-1:0]  count_next;

  assign in_ready  = (state == LOAD);
  assign in_take   = in_valid && in_ready;
  assign store     = (count < CNT_W'(OPERAND_WORDS));
  assign first     = (wcnt == '0);
  assign last_word = (wcnt == CNT_W'(W - 1));
  assign last_bit  = (bcnt == BIT_W'(BITS - 1));

  always_comb begin
    dcur = dsel ? d_t[0] : d_s[0];
    acur = asel ? a_t[0] : a_s[0];
    din  = first ? ((state == REDUCE) ? mc[BITS-1] : 1'b0) : dtop;
    dbin = first ? 1'b0 : dbor;
    acin = first ? 1'b0 : acar;
    abin = first ? 1'b0 : abor;
    abit = (state == MULT) && mult[0];
    mnz_next   = ((count == '0) ? 1'b0 : mnz) || (store && (modulus_word != '0));
    count_next = store ? count + CNT_W'(1) : count;
  end

  imm_slice u_slice (
    .dcur  (dcur),
    .m     (mring[0]),
    .din   (din),
    .dbin  (dbin),
    .acur  (acur),
    .abit  (abit),
    .acin  (acin),
    .abin  (abin),
    .ds    (ds),
    .dt    (dt),
    .dbout (dbout),
    .as    (as),
    .at    (at),
    .acout (acout),
    .about (about)
  );

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    case (state)
      LOAD: begin
        if (in_take) begin
          // The first transaction of a run clears the modulus and S rings, so
          // the words above the loaded count read as zero.
          if (count == '0) begin
            for (int i = 0; i < W; i++) begin
              mring[i] <= '0;
              d_s[i]   <= '0;
              a_s[i]   <= '0;
            end
            mult <= '0;
            mc   <= '0;
            dsel <= 1'b0;
            asel <= 1'b0;
          end
          if (store) begin
            mring[count]                <= modulus_word;
            mult[count*WORD_W +: WORD_W] <= multiplier_word;
            mc[count*WORD_W +: WORD_W]   <= multiplicand_word;
          end
          count <= count_next;
          mnz   <= mnz_next;
          wcnt  <= '0;
          bcnt  <= '0;
          sig   <= '0;
          if (final_word) begin
            state <= mnz_next ? REDUCE : SCAN;
          end
        end
      end
      REDUCE, MULT: begin
        // One word of the pass: the doubling value always, the accumulator
        // only while multiplier bits are applied.
        for (int i = 0; i < W - 1; i++) begin
          mring[i] <= mring[i+1];
          d_s[i]   <= d_s[i+1];
          d_t[i]   <= d_t[i+1];
        end
        mring[W-1] <= mring[0];
        d_s[W-1]   <= ds;
        d_t[W-1]   <= dt;
        dtop <= dcur[WORD_W-1];
        dbor <= dbout;
        if (state == MULT) begin
          for (int i = 0; i < W - 1; i++) begin
            a_s[i] <= a_s[i+1];
            a_t[i] <= a_t[i+1];
          end
          a_s[W-1] <= as;
          a_t[W-1] <= at;
          acar <= acout;
          abor <= about;
        end
        wcnt <= wcnt + CNT_W'(1);
        if (last_word) begin
          wcnt <= '0;
          dsel <= !dbout;
          bcnt <= bcnt + BIT_W'(1);
          if (state == REDUCE) begin
            mc <= {mc[BITS-2:0], 1'b0};
            if (last_bit) begin
              bcnt  <= '0;
              state <= MULT;
            end
          end else begin
            asel <= !about;
            mult <= {1'b0, mult[BITS-1:1]};
            if (last_bit) begin
              state <= SCAN;
            end
          end
        end
      end
      SCAN: begin
        // Fold the selected accumulator into the S ring and find the
        // highest nonzero word among the loaded ones.
        for (int i = 0; i < W - 1; i++) begin
          a_s[i] <= a_s[i+1];
          a_t[i] <= a_t[i+1];
        end
        a_s[W-1] <= acur;
        a_t[W-1] <= a_t[0];
        if ((acur != '0) && (wcnt < count)) begin
          sig <= wcnt + CNT_W'(1);
        end
        wcnt <= wcnt + CNT_W'(1);
        if (last_word) begin
          wcnt  <= '0;
          asel  <= 1'b0;
          state <= EMIT;
        end
      end
      EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid         <= 1'b1;
          product_word      <= a_s[0];
          significant_words <= SIG_W'(sig);
          modulus_zero      <= !mnz;
          final_result      <= (wcnt == count - CNT_W'(1));
          for (int i = 0; i < W - 1; i++) begin
            a_s[i] <= a_s[i+1];
          end
          a_s[W-1] <= a_s[0];
          wcnt <= wcnt + CNT_W'(1);
          if (wcnt == count - CNT_W'(1)) begin
            count <= '0;
            wcnt  <= '0;
            state <= LOAD;
          end
        end
      end
      default: begin
        state <= LOAD;
      end
    endcase
    if (rst) begin
      state     <= LOAD;
      out_valid <= 1'b0;
      count     <= '0;
      wcnt      <= '0;
      bcnt      <= '0;
      mnz       <= 1'b0;
      dsel      <= 1'b0;
      asel      <= 1'b0;
    end
  end

  // A final transaction always leaves the load state.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && final_word) |=> (state != LOAD))
    else $error("final transaction did not start a run");

  // Results are only emitted for a run with at least one loaded word.
  assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (count != '0))
    else $error("emitting with no loaded words");

  // A zero modulus gives zero product words.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && modulus_zero) |-> (product_word == '0))
    else $error("nonzero product with zero modulus");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for interleaved_modular_multiply_top.
// Depends on imm_pkg and the block's RTL; loads operand runs and checks each product word.
`timescale 1ns / 100ps

module testbench;
  import imm_pkg::*;

  localparam int N_WORDS = DEF_OPERAND_WORDS;
  localparam int WIDE = 2 * WORD_W * N_WORDS;

  // One expected product word, as it should appear on the result channel.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [SIG_W-1:0]  sig;
    logic              mzero;
    logic              last;
  } product_t;

  // One row of the directed table. Where known is set, the row closes a
  // single-word run whose answer is typed in; otherwise the predictor decides.
  typedef struct packed {
    logic [WORD_W-1:0] mult;
    logic [WORD_W-1:0] mcand;
    logic [WORD_W-1:0] modw;
    logic              fin;
    logic              known;
    product_t          answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WORD_W-1:0] multiplier_word = '0;
  logic [WORD_W-1:0] multiplicand_word = '0;
  logic [WORD_W-1:0] modulus_word = '0;
  logic final_word = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] product_word;
  logic [SIG_W-1:0] significant_words;
  logic modulus_zero;
  logic final_result;

  // Expected product words, oldest first.
  product_t product_q[$];
  // Operand words held for the run being loaded (at most N_WORDS are kept).
  logic [WORD_W-1:0] held_mult[$];
  logic [WORD_W-1:0] held_mcand[$];
  logic [WORD_W-1:0] held_mod[$];

  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycle_count = 0;
  longint hold_end = 0;

  interleaved_modular_multiply_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .multiplier_word(multiplier_word), .multiplicand_word(multiplicand_word),
    .modulus_word(modulus_word), .final_word(final_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .product_word(product_word), .significant_words(significant_words),
    .modulus_zero(modulus_zero), .final_result(final_result)
  );

  always #1 clk = ~clk;

  // The run is bounded by a generous fixed time; a healthy run ends long before.
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: stalls at the phase's rate, and holds off completely while the
  // cycle counter is below hold_end so that results back up into the block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count < hold_end) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Outputs are sampled at the falling edge, where they are stable; a word
  // seen with valid and ready high there is taken at the next rising edge.
  always @(negedge clk) begin
    product_t got;
    product_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{product_word, significant_words, modulus_zero, final_result};
      if (product_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product transaction %p", got);
      end else begin
        want = product_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("product mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // Works out the reduced product of the held operands and queues one
  // expected word per held word. The block's interleaved steps always yield
  // the exact product modulo the modulus, so plain wide arithmetic suffices.
  function automatic void mod_mult_predict();
    logic [WIDE-1:0] a;
    logic [WIDE-1:0] b;
    logic [WIDE-1:0] m;
    logic [WIDE-1:0] r;
    logic [SIG_W-1:0] sig;
    int n;
    n = held_mult.size();
    a = '0;
    b = '0;
    m = '0;
    for (int i = 0; i < n; i++) begin
      a[WORD_W*i +: WORD_W] = held_mult[i];
      b[WORD_W*i +: WORD_W] = held_mcand[i];
      m[WORD_W*i +: WORD_W] = held_mod[i];
    end
    r = (m == '0) ? '0 : (a * b) % m;
    sig = '0;
    for (int i = 0; i < n; i++) begin
      if (r[WORD_W*i +: WORD_W] != '0) sig = SIG_W'(i + 1);
    end
    for (int i = 0; i < n; i++) begin
      product_q.push_back('{r[WORD_W*i +: WORD_W], sig, (m == '0), (i == n - 1)});
    end
    held_mult.delete();
    held_mcand.delete();
    held_mod.delete();
  endfunction

  // Offers one input transaction and returns at the edge that accepts it,
  // leaving valid high so a following item can go out with no gap.
  task automatic send_word(input logic [WORD_W-1:0] mult, input logic [WORD_W-1:0] mcand,
                           input logic [WORD_W-1:0] modw, input logic fin);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    multiplier_word <= mult;
    multiplicand_word <= mcand;
    modulus_word <= modw;
    final_word <= fin;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (held_mult.size() < N_WORDS) begin
      held_mult.push_back(mult);
      held_mcand.push_back(mcand);
      held_mod.push_back(modw);
    end
  endtask

  // Drops valid and waits until every expected product word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Sends one run of len words with random content. Some runs get an all-zero
  // modulus, which the block must flag.
  task automatic send_run(input int len);
    logic zero_mod;
    zero_mod = ($urandom_range(19) == 0);
    for (int i = 0; i < len; i++) begin
      send_word(rand_word(), rand_word(), zero_mod ? '0 : rand_word(), (i == len - 1));
    end
    mod_mult_predict();
  endtask

  function automatic int run_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(4, 1);
    if (pick < 92) return $urandom_range(N_WORDS - 1, 5);
    return N_WORDS;
  endfunction

  stim_row_t directed[] = '{
    // Zero modulus: the product is zero and the error flag is raised.
    '{16'h0005, 16'h0007, 16'h0000, 1'b1, 1'b1, '{16'h0000, 5'd0, 1'b1, 1'b1}},
    // A modulus of one always gives zero.
    '{16'hFFFF, 16'hFFFF, 16'h0001, 1'b1, 1'b1, '{16'h0000, 5'd0, 1'b0, 1'b1}},
    // Zero multiplier.
    '{16'h0000, 16'h1234, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, 5'd0, 1'b0, 1'b1}},
    '{16'h0003, 16'h0005, 16'hFFFF, 1'b1, 1'b1, '{16'h000F, 5'd1, 1'b0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, 5'd0, 1'b0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 1'b1, '{16'h0001, 5'd1, 1'b0, 1'b1}},
    // Multiplicand well above the modulus is reduced first.
    '{16'h0003, 16'h1234, 16'h0100, 1'b1, 1'b1, '{16'h009C, 5'd1, 1'b0, 1'b1}},
    // Two-word runs: all ones, zero modulus, and a product with a zero top word.
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1, 1'b0, '0},
    '{16'h0001, 16'h0001, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h0001, 16'h0001, 16'h0000, 1'b1, 1'b0, '0},
    '{16'h0002, 16'h0003, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 16'h0000, 16'h0001, 1'b1, 1'b0, '0},
    // Three words, alternating bit patterns.
    '{16'hAAAA, 16'h5555, 16'h8001, 1'b0, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 16'h7FFE, 1'b0, 1'b0, '0},
    '{16'h8000, 16'h0001, 16'h0001, 1'b1, 1'b0, '0}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, with no idling on either side.
    foreach (directed[i]) begin
      send_word(directed[i].mult, directed[i].mcand, directed[i].modw, directed[i].fin);
      if (directed[i].fin) begin
        if (directed[i].known) begin
          product_q.push_back(directed[i].answer);
          held_mult.delete();
          held_mcand.delete();
          held_mod.delete();
        end else begin
          mod_mult_predict();
        end
      end
    end
    drain();

    // A run longer than the block holds: the extra words must be dropped.
    send_run(N_WORDS + 4);
    drain();

    // Random runs in four idling phases; each phase ends once all results are in.
    for (int phase = 0; phase < 4; phase++) begin
      int sent;
      int len;
      idle_pct = (phase == 1) ? 83 : (phase == 3) ? 12 : 0;
      stall_pct = (phase == 2) ? 83 : (phase == 3) ? 12 : 0;
      sent = 0;
      while (sent < 60) begin
        len = run_length();
        send_run(len);
        sent += len;
      end
      drain();
    end

    // Long hold-off on the result side while runs keep coming, so the block
    // fills up and has to stall its input.
    idle_pct = 0;
    stall_pct = 0;
    hold_end = cycle_count + 25000;
    send_run(3);
    send_run(2);
    send_run(4);
    drain();

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
